[sv/swf_hv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swf_hv_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] CfgMinVersion  = 2'd0;
  localparam logic [1:0] CfgMaxVersion  = 2'd1;
  localparam logic [1:0] CfgMinFileSize = 2'd2;

  localparam logic [7:0]  ResetMinVersion  = 8'd3;
  localparam logic [7:0]  ResetMaxVersion  = 8'd20;
  localparam logic [31:0] ResetMinFileSize = 32'd9;

  localparam logic [2:0] VerdictOk      = 3'd0;
  localparam logic [2:0] VerdictVersion = 3'd1;
  localparam logic [2:0] VerdictSize    = 3'd2;
  localparam logic [2:0] VerdictWidth   = 3'd3;
  localparam logic [2:0] VerdictRect    = 3'd4;

  localparam logic [4:0] PosVersion  = 5'd3;
  localparam logic [4:0] PosSizeLo   = 5'd4;
  localparam logic [4:0] PosSizeHi   = 5'd7;
  localparam logic [4:0] PosWidth    = 5'd8;
  localparam logic [4:0] PosLast     = 5'd31;
  localparam logic [4:0] MinFieldWid = 5'd2;

  typedef enum logic [2:0] {
    KindSig,
    KindVer,
    KindSize,
    KindWidth,
    KindRect
  } swf_kind_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_of_header;
  } swf_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] declared_size;
  } swf_out_t;

  typedef struct packed {
    logic [7:0]  min_version;
    logic [7:0]  max_version;
    logic [31:0] min_file_size;
  } swf_cfg_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start;
    swf_kind_e  kind;
    logic [1:0] size_idx;
  } swf_item_t;

endpackage

`default_nettype wire

[sv/swf_hv_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module swf_hv_front import swf_hv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire swf_in_t   in_word_i,
  input  wire logic      push_ready_i,
  output logic           push_valid_o,
  output swf_item_t      push_item_o
);

  logic [4:0] pos_q, pos_d;
  logic [4:0] pos;
  logic       accept;

  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i;
  assign pos          = in_word_i.start_of_header ? 5'd0 : pos_q;

  always_comb begin
    push_item_o.header_byte = in_word_i.header_byte;
    push_item_o.start       = in_word_i.start_of_header;
    push_item_o.size_idx    = pos[1:0];
    if (pos < PosVersion) begin
      push_item_o.kind = KindSig;
    end else if (pos == PosVersion) begin
      push_item_o.kind = KindVer;
    end else if (pos >= PosSizeLo && pos <= PosSizeHi) begin
      push_item_o.kind = KindSize;
    end else if (pos == PosWidth) begin
      push_item_o.kind = KindWidth;
    end else begin
      push_item_o.kind = KindRect;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = (pos < PosLast) ? pos + 5'd1 : PosLast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

[sv/swf_hv_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module swf_hv_queue import swf_hv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  input  wire swf_item_t push_item_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output swf_item_t      pop_item_o,
  input  wire logic      pop_ready_i
);

  swf_item_t  mem_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'(QueueDepth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[sv/swf_hv_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module swf_hv_back import swf_hv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire swf_cfg_t  cfg_i,
  input  wire logic      item_valid_i,
  input  wire swf_item_t item_i,
  output logic           item_ready_o,
  output logic           out_valid_o,
  output swf_out_t       out_word_o,
  input  wire logic      out_ready_i
);

  logic        given_q, given_d;
  logic [31:0] acc_q, acc_d;
  logic [4:0]  fw_q, fw_d;
  logic [1:0]  fn_q, fn_d;
  logic [4:0]  bl_q, bl_d;
  logic        sign_q, sign_d;
  logic        nz_q, nz_d;
  logic        bf_q, bf_d;
  logic        out_valid_q, out_valid_d;
  swf_out_t    out_word_q, out_word_d;
  logic        pop;
  logic        emit;
  logic [2:0]  verdict;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;

  always_comb begin
    logic [7:0] b;
    logic [2:0] first;
    logic       run_bits;
    logic       done;
    logic       bit_v;
    b        = item_i.header_byte;
    first    = 3'd7;
    run_bits = 1'b0;
    done     = 1'b0;
    bit_v    = 1'b0;
    given_d  = given_q;
    acc_d    = acc_q;
    fw_d     = fw_q;
    fn_d     = fn_q;
    bl_d     = bl_q;
    sign_d   = sign_q;
    nz_d     = nz_q;
    bf_d     = bf_q;
    emit     = 1'b0;
    verdict  = VerdictOk;
    if (pop) begin
      if (item_i.start) begin
        given_d = 1'b0;
        acc_d   = 32'd0;
        fw_d    = 5'd0;
        fn_d    = 2'd0;
        bl_d    = 5'd0;
        sign_d  = 1'b0;
        nz_d    = 1'b0;
        bf_d    = 1'b0;
      end
      if (!given_d) begin
        case (item_i.kind)
          KindVer: begin
            if (b < cfg_i.min_version || b > cfg_i.max_version) begin
              emit    = 1'b1;
              verdict = VerdictVersion;
            end
          end
          KindSize: begin
            acc_d = acc_d | ({24'd0, b} << {item_i.size_idx, 3'b000});
            if (item_i.size_idx == 2'd3 && acc_d < cfg_i.min_file_size) begin
              emit    = 1'b1;
              verdict = VerdictSize;
            end
          end
          KindWidth: begin
            fw_d = b[7:3];
            if (fw_d < MinFieldWid) begin
              emit    = 1'b1;
              verdict = VerdictWidth;
            end else begin
              fn_d     = 2'd0;
              bl_d     = fw_d;
              bf_d     = 1'b0;
              run_bits = 1'b1;
              first    = 3'd2;
            end
          end
          KindRect: begin
            run_bits = 1'b1;
          end
          default: begin
          end
        endcase
        if (run_bits) begin
          for (int i = 7; i >= 0; i--) begin
            if (3'(i) <= first && !done) begin
              bit_v = b[i];
              if (bl_d == fw_d) begin
                sign_d = bit_v;
                nz_d   = bit_v;
              end else if (bit_v) begin
                nz_d = 1'b1;
              end
              bl_d = bl_d - 5'd1;
              if (bl_d == 5'd0) begin
                if (!fn_d[0]) begin
                  if (nz_d) begin
                    bf_d = 1'b1;
                  end
                end else if (sign_d || !nz_d) begin
                  bf_d = 1'b1;
                end
                if (fn_d == 2'd3) begin
                  done = 1'b1;
                end else begin
                  fn_d = fn_d + 2'd1;
                  bl_d = fw_d;
                end
              end
            end
          end
          if (done) begin
            emit    = 1'b1;
            verdict = bf_d ? VerdictRect : VerdictOk;
          end
        end
        if (emit) begin
          given_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (pop && emit) begin
      out_valid_d              = 1'b1;
      out_word_d.verdict       = verdict;
      out_word_d.declared_size = (verdict == VerdictVersion) ? 32'd0 : acc_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      given_q     <= 1'b1;
      acc_q       <= 32'd0;
      fw_q        <= 5'd0;
      fn_q        <= 2'd0;
      bl_q        <= 5'd0;
      sign_q      <= 1'b0;
      nz_q        <= 1'b0;
      bf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      given_q     <= given_d;
      acc_q       <= acc_d;
      fw_q        <= fw_d;
      fn_q        <= fn_d;
      bl_q        <= bl_d;
      sign_q      <= sign_d;
      nz_q        <= nz_d;
      bf_q        <= bf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

[sv/swf_header_validator_core.sv]
// Checks the header of an uncompressed flash file, one byte per word, with
// start_of_header marking byte 0. Gives one verdict word (with the declared
// little-endian size from bytes 4 to 7) per header: 0 accepted, 1 version
// outside [min_version, max_version], 2 size below min_file_size, 3 field
// width below 2, 4 frame rectangle not at the origin or not positive. Bytes
// after a verdict are dropped until the next start flag. Takes one byte per
// cycle while the queue has room; a verdict passes the two-entry queue
// between the position tracker and the parser, then the output register.
// The user must write configuration registers through cfg_we_i, cfg_index_i
// and cfg_data_i only while no header is in flight; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module swf_header_validator_core import swf_hv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire swf_in_t     in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output swf_out_t         out_word_o
);

  swf_cfg_t  cfg_q;
  logic      push_valid, push_ready;
  swf_item_t push_item;
  logic      pop_valid, pop_ready;
  swf_item_t pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_version   <= ResetMinVersion;
      cfg_q.max_version   <= ResetMaxVersion;
      cfg_q.min_file_size <= ResetMinFileSize;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMinVersion:  cfg_q.min_version   <= cfg_data_i[7:0];
        CfgMaxVersion:  cfg_q.max_version   <= cfg_data_i[7:0];
        CfgMinFileSize: cfg_q.min_file_size <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = push_ready;

  swf_hv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_word_i    (in_word_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_item_o  (push_item)
  );

  swf_hv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  swf_hv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (pop_valid),
    .item_i       (pop_item),
    .item_ready_o (pop_ready),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import swf_hv_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned Latency    = 8;
  localparam int unsigned PhaseItems = 35;

  class header_scoreboard;
    logic [7:0]  min_ver;
    logic [7:0]  max_ver;
    logic [31:0] min_size;
    logic [4:0]  pos;
    bit          done;
    logic [31:0] size_acc;
    logic [4:0]  fwidth;
    logic [1:0]  fnum;
    logic [4:0]  bits_left;
    bit          fsign;
    bit          fnz;
    bit          rect_bad;
    swf_out_t    expected_verdicts[$];
    int          errors;

    function new();
      min_ver  = ResetMinVersion;
      max_ver  = ResetMaxVersion;
      min_size = ResetMinFileSize;
      clear_header();
      done   = 1'b1;
      errors = 0;
    endfunction

    function void clear_header();
      pos       = '0;
      done      = 1'b0;
      size_acc  = '0;
      fwidth    = '0;
      fnum      = '0;
      bits_left = '0;
      fsign     = 1'b0;
      fnz       = 1'b0;
      rect_bad  = 1'b0;
    endfunction

    function void configure(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CfgMinVersion:  min_ver  = data[7:0];
        CfgMaxVersion:  max_ver  = data[7:0];
        CfgMinFileSize: min_size = data;
        default: ;
      endcase
    endfunction

    // one rectangle bit; returns 1 when Ymax is complete
    function bit take_bit(bit b);
      if (bits_left == fwidth) begin
        fsign = b;
        fnz   = b;
      end else if (b) begin
        fnz = 1'b1;
      end
      bits_left = bits_left - 5'd1;
      if (bits_left != 0) return 1'b0;
      if (fnum[0] == 1'b0) begin
        if (fnz) rect_bad = 1'b1;
      end else begin
        if (fsign || !fnz) rect_bad = 1'b1;
      end
      if (fnum == 2'd3) return 1'b1;
      fnum      = fnum + 2'd1;
      bits_left = fwidth;
      return 1'b0;
    endfunction

    function void note_byte(swf_in_t w);
      logic [7:0] b;
      logic [2:0] v;
      bit         have;
      int         first;
      int         i;
      swf_out_t   r;
      b     = w.header_byte;
      have  = 1'b0;
      v     = VerdictOk;
      first = 7;
      if (w.start_of_header) clear_header();
      if (done) return;
      if (pos == PosVersion) begin
        if (b < min_ver || b > max_ver) begin
          have = 1'b1;
          v    = VerdictVersion;
        end
      end else if (pos >= PosSizeLo && pos <= PosSizeHi) begin
        size_acc = size_acc | (32'(b) << (8 * (pos - PosSizeLo)));
        if (pos == PosSizeHi && size_acc < min_size) begin
          have = 1'b1;
          v    = VerdictSize;
        end
      end else if (pos >= PosWidth) begin
        if (pos == PosWidth) begin
          fwidth = b[7:3];
          if (fwidth < MinFieldWid) begin
            have = 1'b1;
            v    = VerdictWidth;
          end else begin
            fnum      = '0;
            bits_left = fwidth;
            rect_bad  = 1'b0;
          end
          first = 2;
        end
        if (!have) begin
          for (i = first; i >= 0; i--) begin
            if (take_bit(b[i])) begin
              have = 1'b1;
              v    = rect_bad ? VerdictRect : VerdictOk;
              break;
            end
          end
        end
      end
      if (pos != PosLast) pos = pos + 5'd1;
      if (!have) return;
      done            = 1'b1;
      r.verdict       = v;
      r.declared_size = (v == VerdictVersion) ? 32'd0 : size_acc;
      expected_verdicts.push_back(r);
    endfunction

    function void check_verdict(swf_out_t r);
      swf_out_t e;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected verdict word: verdict %0d, declared_size %0d",
               r.verdict, r.declared_size);
        errors++;
        return;
      end
      e = expected_verdicts.pop_front();
      if (r.verdict !== e.verdict) begin
        $error("verdict: expected %0d, actual %0d", e.verdict, r.verdict);
        errors++;
      end
      if (r.declared_size !== e.declared_size) begin
        $error("declared_size: expected %0d, actual %0d", e.declared_size, r.declared_size);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  swf_in_t     in_word;
  logic        out_valid;
  logic        out_ready;
  swf_out_t    out_word;

  header_scoreboard sb;
  bit          idle_on;
  bit          quiet;
  bit          hold_req;
  int          fed;
  int unsigned idle_cycles;

  swf_header_validator_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_verdict(out_word);
      if (in_valid && in_ready) sb.note_byte(in_word);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("swf_header_validator_core: mismatch");
      $finish;
    end
  end

  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready = 1'b0;
        stall     = $urandom_range(0, 15);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_word(input swf_in_t w);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.configure(idx, data);
  endtask

  task automatic set_config(input logic [7:0] lo, input logic [7:0] hi,
                            input logic [31:0] min_size);
    wait_drained();
    write_reg(CfgMinVersion, {24'd0, lo});
    write_reg(CfgMaxVersion, {24'd0, hi});
    write_reg(CfgMinFileSize, min_size);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_header(input logic [7:0] ver, input logic [31:0] size, input int w,
                             input logic [31:0] f0, input logic [31:0] f1,
                             input logic [31:0] f2, input logic [31:0] f3,
                             input int keep, input int trail);
    logic [7:0]  hdr[$];
    bit          bits[$];
    logic [31:0] f[4];
    logic [7:0]  b;
    swf_in_t     word;
    int          i;
    int          k;
    int          n;
    f[0] = f0;
    f[1] = f1;
    f[2] = f2;
    f[3] = f3;
    for (i = 0; i < 3; i++) hdr.push_back(8'($urandom));
    hdr.push_back(ver);
    for (i = 0; i < 4; i++) hdr.push_back(size[8*i +: 8]);
    for (i = 4; i >= 0; i--) bits.push_back(w[i]);
    for (k = 0; k < 4; k++)
      for (i = w - 1; i >= 0; i--) bits.push_back(f[k][i]);
    while (bits.size() % 8 != 0) bits.push_back(bit'($urandom_range(0, 1)));
    for (i = 0; i < bits.size(); i += 8) begin
      for (k = 0; k < 8; k++) b[7-k] = bits[i+k];
      hdr.push_back(b);
    end
    n = (keep > 0 && keep < hdr.size()) ? keep : hdr.size();
    for (i = 0; i < n; i++) begin
      word.header_byte     = hdr[i];
      word.start_of_header = (i == 0);
      send_word(word);
      fed++;
    end
    for (i = 0; i < trail; i++) begin
      word.header_byte     = 8'($urandom);
      word.start_of_header = 1'b0;
      send_word(word);
    end
  endtask

  function automatic logic [31:0] pick_origin(input int w);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 32'd0;
    if (roll < 90 && w >= 1) return 32'd1 << (w - 1);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_extent(input int w);
    int roll;
    roll = $urandom_range(0, 99);
    if (w < 2) return $urandom;
    if (roll < 70) return $urandom_range(1, (32'd1 << (w - 1)) - 1);
    if (roll < 80) return 32'd0;
    if (roll < 90) return 32'd1 << (w - 1);
    return $urandom;
  endfunction

  task automatic rand_header();
    logic [7:0]  ver;
    logic [31:0] size;
    int          w;
    int          roll;
    int          keep;
    int          trail;
    int          total;
    roll = $urandom_range(0, 99);
    if (roll < 80 && sb.min_ver <= sb.max_ver) ver = $urandom_range(sb.max_ver, sb.min_ver);
    else ver = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 80) size = sb.min_size + 32'($urandom % (64'h1_0000_0000 - sb.min_size));
    else if (roll < 90) size = $urandom_range(0, 20);
    else size = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 70) w = $urandom_range(2, 8);
    else if (roll < 85) w = $urandom_range(9, 30);
    else if (roll < 93) w = 31;
    else w = $urandom_range(0, 1);
    total = 8 + (5 + 4 * w + 7) / 8;
    keep  = 0;
    trail = 0;
    roll  = $urandom_range(0, 99);
    if (roll < 10) keep = $urandom_range(1, total - 1);
    else if (roll < 35) trail = $urandom_range(1, 3);
    send_header(ver, size, w, pick_origin(w), pick_extent(w), pick_origin(w), pick_extent(w),
                keep, trail);
  endtask

  task automatic run_random(input int n);
    int      target;
    swf_in_t word;
    target = fed + n;
    while (fed < target) begin
      if (!quiet && $urandom_range(0, 9) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 99) < 5) begin
        repeat ($urandom_range(1, 4)) begin
          word.header_byte     = 8'($urandom);
          word.start_of_header = ($urandom_range(0, 2) == 0);
          send_word(word);
          fed++;
        end
      end else begin
        rand_header();
      end
    end
  endtask

  initial begin
    logic [7:0] lo;
    swf_in_t    word;
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CfgMinVersion;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_word     = '0;
    idle_on     = 1'b1;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    fed         = 0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // ignored while idle, then one header per early verdict, then a pass
    word.header_byte     = 8'hFF;
    word.start_of_header = 1'b0;
    send_word(word);
    send_header(8'd2, 32'd100, 4, 32'd0, 32'd5, 32'd0, 32'd5, 4, 1);
    send_header(8'd3, 32'd8, 4, 32'd0, 32'd5, 32'd0, 32'd5, 8, 0);
    send_header(8'd20, 32'd9, 1, 32'd0, 32'd0, 32'd0, 32'd0, 9, 0);
    send_header(8'd3, 32'hFFFF_FFFF, 2, 32'd0, 32'd1, 32'd0, 32'd1, 0, 0);
    run_random(PhaseItems);

    set_config(8'd0, 8'd255, 32'd0);
    run_random(20);
    hold_req = 1'b1;
    run_random(PhaseItems);
    wait_drained();
    run_random(20);

    set_config(8'd255, 8'd255, 32'hFFFF_FFFF);
    run_random(PhaseItems);

    set_config(8'd20, 8'd3, 32'd9);
    run_random(PhaseItems);

    repeat (2) begin
      lo = $urandom_range(0, 255);
      set_config(lo, $urandom_range(lo, 255),
                 ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000));
      run_random(PhaseItems);
    end

    set_config(ResetMinVersion, ResetMaxVersion, ResetMinFileSize);
    quiet   = 1'b1;
    idle_on = 1'b0;
    run_random(PhaseItems);
    wait_drained();

    if (sb.expected_verdicts.size() != 0) begin
      $error("%0d verdict words never arrived", sb.expected_verdicts.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("swf_header_validator_core: match");
    end else begin
      $display("swf_header_validator_core: mismatch");
    end
    $finish;
  end

endmodule
